// File: src/fud_pkg.sv
// Package for the form body decoder: character codes, marker kinds,
// escape phases, the result entry type and the hex digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package fud_pkg;

  // Most results that one input byte can cause.
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  // Characters with a meaning of their own in a form body.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Kind of boundary marker carried by a result.
  typedef enum logic [1:0] {
    END_NONE    = 2'd0,
    END_KEY     = 2'd1,
    END_ACCEPT  = 2'd2,
    END_DISCARD = 2'd3
  } end_kind_t;

  // Progress through a percent escape.
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX  = 2'd2
  } esc_phase_t;

  // One result as it waits in the output buffer.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       in_value;
    end_kind_t  end_kind;
  } entry_t;

  // True when the character is a hex digit of either case.
  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  // Value of a hex digit; only meaningful when hex_ok holds.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
    end else begin
      d = c - 8'h37;
    end
    hex_val = d[3:0];
  endfunction

  // A result carrying a decoded byte.
  function automatic entry_t mk_byte(input logic [7:0] b, input logic part);
    entry_t e;
    e.has_byte = 1'b1;
    e.out_byte = b;
    e.in_value = part;
    e.end_kind = END_NONE;
    mk_byte = e;
  endfunction

  // A boundary marker result.
  function automatic entry_t mk_marker(input end_kind_t kind, input logic part);
    entry_t e;
    e.has_byte = 1'b0;
    e.out_byte = 8'h00;
    e.in_value = part;
    e.end_kind = kind;
    mk_marker = e;
  endfunction

endpackage

// File: src/fud_in_if.sv
// Input channel of the form body decoder: one raw body byte per request.
// No dependencies.
`timescale 1ns / 1ps

interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_body;

  modport source (output valid, output in_byte, output end_of_body, input ready);
  modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface

// File: src/fud_out_if.sv
// Result channel of the form body decoder: one decoded byte or marker per request.
// No dependencies.
`timescale 1ns / 1ps

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       in_value;
  logic [1:0] end_kind;
  logic       last_of_run;

  modport source (output valid, output has_byte, output out_byte, output in_value,
                  output end_kind, output last_of_run, input ready);
  modport sink   (input valid, input has_byte, input out_byte, input in_value,
                  input end_kind, input last_of_run, output ready);
endinterface

// File: src/form_urlencoded_decoder.sv
// Form body decoder: first result in the cycle after a byte is accepted, then one
// result per cycle while the output is ready. A byte that causes n results (0 to 4)
// holds the output buffer until all n have left; the next byte is taken in the cycle
// the last of them leaves, so plain bytes flow at one per cycle while the output is
// ready. The single four-entry output buffer sets this. Synchronous active-low
// reset returns to the key part with no escape pending and an empty buffer.
`timescale 1ns / 1ps

module form_urlencoded_decoder (
  input  logic      clk,
  input  logic      rst_n,
  fud_in_if.sink    in_ch,
  fud_out_if.source out_ch
);
  import fud_pkg::*;

  // Decoder state.
  logic       value_part_r, value_part_nxt;
  esc_phase_t esc_phase_r, esc_phase_nxt;
  logic [7:0] held_r, held_nxt;

  // Output buffer: the results of the last accepted byte.
  entry_t             list_r [MAX_RESULTS];
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // Results worked out for the byte on the input.
  entry_t             res [MAX_RESULTS];
  logic [CNT_W-1:0]   cnt;

  logic       in_fire, out_fire;
  logic [7:0] b;
  logic       is_amp, is_delim, b_hex, consumed;
  entry_t     cur;

  assign b        = in_ch.in_byte;
  assign is_amp   = (b == CH_AMP);
  assign is_delim = is_amp || (b == CH_EQ && !value_part_r);
  assign b_hex    = hex_ok(b);

  // Handshakes: a new byte is taken once the buffer empties or drains this cycle.
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (rem_r == '0) ||
                       (rem_r == CNT_W'(1) && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Decode one byte into its list of results and the next state.
  always_comb begin
    value_part_nxt = value_part_r;
    esc_phase_nxt  = esc_phase_r;
    held_nxt       = held_r;
    consumed       = 1'b0;
    cnt            = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = mk_marker(END_NONE, 1'b0);
    end

    // Continue or abandon a pending escape.
    case (esc_phase_r)
      ESC_PCT: begin
        if (!is_delim && b_hex) begin
          held_nxt      = b;
          esc_phase_nxt = ESC_HEX;
          consumed      = 1'b1;
        end else begin
          res[cnt[IDX_W-1:0]] = mk_byte(CH_PCT, value_part_r);
          cnt = cnt + CNT_W'(1);
          esc_phase_nxt = ESC_NONE;
        end
      end
      ESC_HEX: begin
        if (b_hex) begin
          res[cnt[IDX_W-1:0]] = mk_byte({hex_val(held_r), hex_val(b)}, value_part_r);
          cnt = cnt + CNT_W'(1);
          consumed = 1'b1;
        end else begin
          res[cnt[IDX_W-1:0]] = mk_byte(CH_PCT, value_part_r);
          cnt = cnt + CNT_W'(1);
          res[cnt[IDX_W-1:0]] = mk_byte(held_r, value_part_r);
          cnt = cnt + CNT_W'(1);
        end
        esc_phase_nxt = ESC_NONE;
      end
      default: begin
        esc_phase_nxt = ESC_NONE;
      end
    endcase

    // Handle the byte itself unless the escape took it.
    if (!consumed) begin
      if (is_amp) begin
        res[cnt[IDX_W-1:0]] = mk_marker(value_part_r ? END_ACCEPT : END_DISCARD,
                                        value_part_r);
        cnt = cnt + CNT_W'(1);
        value_part_nxt = 1'b0;
      end else if (is_delim) begin
        res[cnt[IDX_W-1:0]] = mk_marker(END_KEY, value_part_r);
        cnt = cnt + CNT_W'(1);
        value_part_nxt = 1'b1;
      end else if (b == CH_PCT) begin
        esc_phase_nxt = ESC_PCT;
      end else if (b == CH_PLUS) begin
        res[cnt[IDX_W-1:0]] = mk_byte(CH_SPACE, value_part_r);
        cnt = cnt + CNT_W'(1);
      end else begin
        res[cnt[IDX_W-1:0]] = mk_byte(b, value_part_r);
        cnt = cnt + CNT_W'(1);
      end
    end

    // End of body: flush any escape, close the pair and start afresh.
    if (in_ch.end_of_body) begin
      if (esc_phase_nxt inside {ESC_PCT, ESC_HEX}) begin
        res[cnt[IDX_W-1:0]] = mk_byte(CH_PCT, value_part_nxt);
        cnt = cnt + CNT_W'(1);
      end
      if (esc_phase_nxt == ESC_HEX) begin
        res[cnt[IDX_W-1:0]] = mk_byte(held_nxt, value_part_nxt);
        cnt = cnt + CNT_W'(1);
      end
      if (!is_amp) begin
        res[cnt[IDX_W-1:0]] = mk_marker(value_part_nxt ? END_ACCEPT : END_DISCARD,
                                        value_part_nxt);
        cnt = cnt + CNT_W'(1);
      end
      value_part_nxt = 1'b0;
      esc_phase_nxt  = ESC_NONE;
    end
  end

  // Buffer bookkeeping: drain one entry per request, reload on a new byte.
  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (out_fire) begin
      rem_nxt = rem_r - CNT_W'(1);
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (in_fire && cnt != '0) begin
      rem_nxt = cnt;
      idx_nxt = '0;
    end
  end

  // Control and decoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_part_r <= 1'b0;
      esc_phase_r  <= ESC_NONE;
      held_r       <= 8'h00;
      rem_r        <= '0;
      idx_r        <= '0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
      if (in_fire) begin
        value_part_r <= value_part_nxt;
        esc_phase_r  <= esc_phase_nxt;
        held_r       <= held_nxt;
      end
    end
  end

  // Result payload, loaded when a byte with results is accepted.
  always_ff @(posedge clk) begin
    if (in_fire && cnt != '0) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        list_r[i] <= res[i];
      end
    end
  end

  // Present the current buffer entry.
  assign cur                = list_r[idx_r];
  assign out_ch.valid       = (rem_r != '0);
  assign out_ch.has_byte    = cur.has_byte;
  assign out_ch.out_byte    = cur.out_byte;
  assign out_ch.in_value    = cur.in_value;
  assign out_ch.end_kind    = cur.end_kind;
  assign out_ch.last_of_run = (rem_r == CNT_W'(1));

endmodule
